@@ design/tdfw_pkg.sv @@
// tdfw_pkg: types and constants shared by the two-wire frame writer.
// No dependencies; imported by the sequencer, output stage and top level.
package tdfw_pkg;

    localparam int unsigned DELAY_W = 16;
    localparam int unsigned BIT_W   = 3;
    localparam int unsigned SUB_W   = 2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;
    localparam logic [BIT_W-1:0]   LAST_BIT    = 3'd7;

    // sub-step codes inside a segment
    localparam logic [SUB_W-1:0] SUB_0 = 2'd0;
    localparam logic [SUB_W-1:0] SUB_1 = 2'd1;
    localparam logic [SUB_W-1:0] SUB_2 = 2'd2;
    localparam logic [SUB_W-1:0] SUB_3 = 2'd3;

    // segments of one frame byte on the link
    typedef enum logic [1:0] {
        SEG_START,
        SEG_BITS,
        SEG_ACK,
        SEG_STOP
    } t_seg;

    // one pin phase as handed from the sequencer to the output stage
    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic delayed;
        logic last_phase;
    } t_phase;

endpackage

@@ design/tdfw_seq.sv @@
// tdfw_seq: input word register and segment/bit/sub-step sequencer.
// Depends on tdfw_pkg; produces one pin phase per step for tdfw_out.
module tdfw_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_frame_byte,
    input  logic                i_first_byte,
    input  logic                i_last_byte,
    input  logic                i_take,
    output logic                o_phase_valid,
    output tdfw_pkg::t_phase    o_phase
);
    import tdfw_pkg::*;

    logic              r_busy;
    logic              n_busy;
    t_seg              r_seg;
    t_seg              n_seg;
    logic [SUB_W-1:0]  r_sub;
    logic [SUB_W-1:0]  n_sub;
    logic [BIT_W-1:0]  r_bit;
    logic [BIT_W-1:0]  n_bit;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              w_seg_end;
    logic              w_step;
    logic              w_accept;
    logic              w_prev;
    t_phase            w_phase;

    assign w_step   = r_busy && i_take;
    assign o_ready  = i_rst_n && (!r_busy || (w_step && w_phase.last_phase));
    assign w_accept = i_valid && o_ready;
    assign w_prev   = (r_bit == '0) ? 1'b0 : r_byte[r_bit - 1'b1];

    // next state
    always_comb begin
        n_busy    = r_busy;
        n_seg     = r_seg;
        n_sub     = r_sub;
        n_bit     = r_bit;
        w_seg_end = 1'b0;
        unique case (r_seg)
            SEG_START: w_seg_end = (r_sub == SUB_1);
            SEG_BITS:  w_seg_end = (r_sub == SUB_2) && (r_bit == LAST_BIT);
            SEG_ACK:   w_seg_end = (r_sub == SUB_2);
            SEG_STOP:  w_seg_end = (r_sub == SUB_3);
            default:   w_seg_end = 1'b1;
        endcase
        if (w_step) begin
            if (w_phase.last_phase) begin
                n_busy = 1'b0;
            end else if (w_seg_end) begin
                n_sub = SUB_0;
                n_bit = '0;
                unique case (r_seg)
                    SEG_START: n_seg = SEG_BITS;
                    SEG_BITS:  n_seg = SEG_ACK;
                    SEG_ACK:   n_seg = SEG_STOP;
                    default:   n_seg = SEG_STOP;
                endcase
            end else if ((r_seg == SEG_BITS) && (r_sub == SUB_2)) begin
                n_sub = SUB_0;
                n_bit = r_bit + 1'b1;
            end else begin
                n_sub = r_sub + 1'b1;
            end
        end
        if (w_accept) begin
            n_busy = 1'b1;
            n_seg  = i_first_byte ? SEG_START : SEG_BITS;
            n_sub  = SUB_0;
            n_bit  = '0;
        end
    end

    // phase decode
    always_comb begin
        w_phase = '0;
        unique case (r_seg)
            SEG_START: begin
                if (r_sub == SUB_0) begin
                    w_phase = '{clk_level: 1'b1, dio_level: 1'b1, delayed: 1'b1,
                                last_phase: 1'b0};
                end else begin
                    w_phase = '{clk_level: 1'b1, dio_level: 1'b0, delayed: 1'b0,
                                last_phase: 1'b0};
                end
            end
            SEG_BITS: begin
                unique case (r_sub)
                    SUB_0: w_phase = '{clk_level: 1'b0, dio_level: w_prev,
                                       delayed: 1'b0, last_phase: 1'b0};
                    SUB_1: w_phase = '{clk_level: 1'b0, dio_level: r_byte[r_bit],
                                       delayed: 1'b1, last_phase: 1'b0};
                    default: w_phase = '{clk_level: 1'b1, dio_level: r_byte[r_bit],
                                         delayed: 1'b1, last_phase: 1'b0};
                endcase
            end
            SEG_ACK: begin
                unique case (r_sub)
                    SUB_0: w_phase = '{clk_level: 1'b0, dio_level: r_byte[LAST_BIT],
                                       delayed: 1'b1, last_phase: 1'b0};
                    SUB_1: w_phase = '{clk_level: 1'b1, dio_level: r_byte[LAST_BIT],
                                       delayed: 1'b1, last_phase: 1'b0};
                    default: w_phase = '{clk_level: 1'b1, dio_level: 1'b0,
                                         delayed: 1'b0, last_phase: !r_last};
                endcase
            end
            default: begin
                unique case (r_sub)
                    SUB_0, SUB_1: w_phase = '{clk_level: 1'b0, dio_level: 1'b0,
                                              delayed: 1'b1, last_phase: 1'b0};
                    SUB_2: w_phase = '{clk_level: 1'b1, dio_level: 1'b0,
                                       delayed: 1'b1, last_phase: 1'b0};
                    default: w_phase = '{clk_level: 1'b1, dio_level: 1'b1,
                                         delayed: 1'b0, last_phase: 1'b1};
                endcase
            end
        endcase
    end

    assign o_phase_valid = r_busy;
    assign o_phase       = w_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= SEG_BITS;
            r_sub  <= SUB_0;
            r_bit  <= '0;
        end else begin
            r_busy <= n_busy;
            r_seg  <= n_seg;
            r_sub  <= n_sub;
            r_bit  <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_frame_byte;
            r_last <= i_last_byte;
        end
    end

endmodule

@@ design/tdfw_out.sv @@
// tdfw_out: result register for one pin phase word with valid/ready.
// Depends on tdfw_pkg; fed by tdfw_seq, hold time taken from the delay register.
module tdfw_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_phase_valid,
    input  tdfw_pkg::t_phase              i_phase,
    input  logic [tdfw_pkg::DELAY_W-1:0]  i_delay_cycles,
    output logic                          o_take,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_clk_level,
    output logic                          o_dio_level,
    output logic [tdfw_pkg::DELAY_W-1:0]  o_hold_cycles,
    output logic                          o_last_phase
);
    import tdfw_pkg::*;

    logic               r_valid;
    logic               n_valid;
    logic               r_clk_level;
    logic               r_dio_level;
    logic [DELAY_W-1:0] r_hold_cycles;
    logic               r_last_phase;
    logic               w_load;

    assign o_take = !r_valid || i_ready;
    assign w_load = i_phase_valid && o_take;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_clk_level   <= i_phase.clk_level;
            r_dio_level   <= i_phase.dio_level;
            r_hold_cycles <= i_phase.delayed ? i_delay_cycles : '0;
            r_last_phase  <= i_phase.last_phase;
        end
    end

    assign o_valid       = r_valid;
    assign o_clk_level   = r_clk_level;
    assign o_dio_level   = r_dio_level;
    assign o_hold_cycles = r_hold_cycles;
    assign o_last_phase  = r_last_phase;

endmodule

@@ design/two_wire_display_frame_writer.sv @@
// two_wire_display_frame_writer: top level of the two-wire frame writer.
// Depends on tdfw_pkg, tdfw_seq and tdfw_out.
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ------------------------------------------
//  frame in  in         i_valid / o_ready     i_frame_byte, i_first_byte, i_last_byte
//  phase out out        o_valid / i_ready     o_clk_level, o_dio_level, o_hold_cycles,
//                                             o_last_phase
//  config    in         i_cfg_we              i_cfg_wdata (delay_cycles)
//
// Phases: each frame word turns into 27 phase words, 29 with a start condition,
//   31 with a stop, 33 with both; one phase word leaves per cycle while i_ready
//   is high, the sequencer stepping one phase each time the result register takes one.
// The next frame word is taken in the cycle its predecessor's final phase goes into
//   the result register, so back-to-back words run with no gap on the output.
// Reset (synchronous, active low) empties the sequencer and result register and
//   sets the delay register to 100; o_ready is low while reset is held.
// A stall on i_ready holds the result register and freezes the sequencer.
module two_wire_display_frame_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // frame words
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_frame_byte,
    input  logic                          i_first_byte,
    input  logic                          i_last_byte,
    // pin phase words
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_clk_level,
    output logic                          o_dio_level,
    output logic [tdfw_pkg::DELAY_W-1:0]  o_hold_cycles,
    output logic                          o_last_phase,
    // delay register write
    input  logic                          i_cfg_we,
    input  logic [tdfw_pkg::DELAY_W-1:0]  i_cfg_wdata
);
    import tdfw_pkg::*;

    logic [DELAY_W-1:0] r_delay_cycles;
    logic               w_take;
    logic               w_phase_valid;
    t_phase             w_phase;

    // delay register; the user must write it only while the block is idle (unchecked)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_cycles <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay_cycles <= i_cfg_wdata;
        end
    end

    // start / data bits / ack clock / stop sequencing
    tdfw_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_byte  (i_frame_byte),
        .i_first_byte  (i_first_byte),
        .i_last_byte   (i_last_byte),
        .i_take        (w_take),
        .o_phase_valid (w_phase_valid),
        .o_phase       (w_phase)
    );

    // result register; resolves hold time from the delay register
    tdfw_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_phase_valid  (w_phase_valid),
        .i_phase        (w_phase),
        .i_delay_cycles (r_delay_cycles),
        .o_take         (w_take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_clk_level    (o_clk_level),
        .o_dio_level    (o_dio_level),
        .o_hold_cycles  (o_hold_cycles),
        .o_last_phase   (o_last_phase)
    );

endmodule

@@ design/tdfw_checker.sv @@
// tdfw_checker: port-level assertions for the two-wire frame writer, and its bind.
// Depends on tdfw_pkg for widths; attaches to two_wire_display_frame_writer.
module tdfw_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic                          o_clk_level,
    input  logic                          o_dio_level,
    input  logic [tdfw_pkg::DELAY_W-1:0]  o_hold_cycles,
    input  logic                          o_last_phase
);

    // an accepted frame word shows a phase word once it has passed the sequencer state and the result register
    a_accept_gives_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> ##1 o_valid)
        else $error("no phase word after frame word accepted");

    // a new frame word is only taken once the pending phase is the final one
    a_ready_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid && !i_ready |-> o_last_phase)
        else $error("frame word taken with phases still outstanding");

    // phases of one frame word come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_phase |=> o_valid)
        else $error("gap inside the phase words of one frame word");

    // stalled phase word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_clk_level) && $stable(o_dio_level)
            && $stable(o_hold_cycles) && $stable(o_last_phase))
        else $error("stalled phase word changed");

endmodule

bind two_wire_display_frame_writer tdfw_checker u_tdfw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_clk_level   (o_clk_level),
    .o_dio_level   (o_dio_level),
    .o_hold_cycles (o_hold_cycles),
    .o_last_phase  (o_last_phase)
);

@@ dv/two_wire_display_frame_writer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the two-wire frame writer: frame words in, pin phase words out.
// Needs tdfw_pkg and two_wire_display_frame_writer; no files, arguments or seeds are read.
module two_wire_display_frame_writer_tb;

    import tdfw_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either channel
    localparam int SETTLE_CYCLES = 40;  // wait after the drain for stray phase words
    localparam int N_DIRECTED = 14;
    localparam int RANDOM_BLOCKS = 5;
    localparam int WORDS_PER_BLOCK = 45;
    localparam int UNTYPED = -1;

    // one expected pin phase, at the block's widths
    typedef struct packed {
        logic               clk_level;
        logic               dio_level;
        logic [DELAY_W-1:0] hold_cycles;
        logic               last_phase;
    } pin_phase_t;

    // directed row: optional delay write before the word, then the word itself
    typedef struct {
        logic               set_delay;
        logic [DELAY_W-1:0] delay;
        logic [7:0]         data;
        logic               first;
        logic               last;
        int                 phases;     // phase count known at a glance, or UNTYPED
    } frame_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_frame_byte = '0;
    logic               i_first_byte = 1'b0;
    logic               i_last_byte = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_clk_level;
    logic               o_dio_level;
    logic [DELAY_W-1:0] o_hold_cycles;
    logic               o_last_phase;
    logic               i_cfg_we = 1'b0;
    logic [DELAY_W-1:0] i_cfg_wdata = '0;

    // bench-side companion of the payload: typed phase count for the word on offer
    int                 word_phases = UNTYPED;

    pin_phase_t         pending_phases[$];  // expected phase words, oldest first
    int                 typed_counts[$];    // one per accepted frame word
    logic [DELAY_W-1:0] delay_shadow = DELAY_RESET;
    int                 phases_this_word = 0;
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    bit                 quiet = 1'b0;       // no idling on either side while set
    frame_row_t         directed_rows [N_DIRECTED];

    two_wire_display_frame_writer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_byte (i_frame_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_clk_level  (o_clk_level),
        .o_dio_level  (o_dio_level),
        .o_hold_cycles(o_hold_cycles),
        .o_last_phase (o_last_phase),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 12 ns period
    always #6 i_clk = ~i_clk;

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // a delayed phase holds the current delay register, any other holds zero
    function automatic pin_phase_t pin(input logic clk, input logic dio, input logic delayed);
        pin_phase_t p;
        p.clk_level   = clk;
        p.dio_level   = dio;
        p.hold_cycles = delayed ? delay_shadow : '0;
        p.last_phase  = 1'b0;
        return p;
    endfunction

    // Expands one frame word into its pin phases and queues them:
    // optional start, 8 bits LSB first, acknowledge clock, optional stop.
    function automatic void expand_frame_word(input logic [7:0] data, input logic first,
                                              input logic last);
        pin_phase_t seq [33];
        int         k;
        logic       prev;
        logic       b;
        k    = 0;
        prev = 1'b0;    // data line left low by the start condition
        if (first) begin
            seq[k] = pin(1'b1, 1'b1, 1'b1); k = k + 1;
            seq[k] = pin(1'b1, 1'b0, 1'b0); k = k + 1;
        end
        for (int i = 0; i < 8; i++) begin
            b = data[i];
            seq[k] = pin(1'b0, prev, 1'b0); k = k + 1;  // clock low, data not yet moved
            seq[k] = pin(1'b0, b, 1'b1);    k = k + 1;  // data set
            seq[k] = pin(1'b1, b, 1'b1);    k = k + 1;  // clock high
            prev = b;
        end
        // acknowledge clock, answer not sampled
        seq[k] = pin(1'b0, prev, 1'b1); k = k + 1;
        seq[k] = pin(1'b1, prev, 1'b1); k = k + 1;
        seq[k] = pin(1'b1, 1'b0, 1'b0); k = k + 1;
        if (last) begin
            seq[k] = pin(1'b0, 1'b0, 1'b1); k = k + 1;
            seq[k] = pin(1'b0, 1'b0, 1'b1); k = k + 1;
            seq[k] = pin(1'b1, 1'b0, 1'b1); k = k + 1;
            seq[k] = pin(1'b1, 1'b1, 1'b0); k = k + 1;
        end
        seq[k-1].last_phase = 1'b1;
        for (int i = 0; i < k; i++) pending_phases.push_back(seq[i]);
    endfunction

    // Monitor: everything that moves is sampled at the rising edge, before the
    // edge's own updates land, so ordering within the step does not matter.
    always @(posedge i_clk) begin
        pin_phase_t exp_ph;
        int         typed;
        if (i_rst_n) begin
            if (i_cfg_we) delay_shadow = i_cfg_wdata;
            if (i_valid && o_ready) begin
                expand_frame_word(i_frame_byte, i_first_byte, i_last_byte);
                typed_counts.push_back(word_phases);
            end
            if (o_valid && i_ready) begin
                phases_this_word = phases_this_word + 1;
                if (pending_phases.size() == 0) begin
                    $error("phase word with nothing expected: clk %0b dio %0b hold %0d last %0b",
                           o_clk_level, o_dio_level, o_hold_cycles, o_last_phase);
                    errors = errors + 1;
                end else begin
                    exp_ph = pending_phases.pop_front();
                    if (o_clk_level !== exp_ph.clk_level) begin
                        $error("clk_level: expected %0b, actual %0b",
                               exp_ph.clk_level, o_clk_level);
                        errors = errors + 1;
                    end
                    if (o_dio_level !== exp_ph.dio_level) begin
                        $error("dio_level: expected %0b, actual %0b",
                               exp_ph.dio_level, o_dio_level);
                        errors = errors + 1;
                    end
                    if (o_hold_cycles !== exp_ph.hold_cycles) begin
                        $error("hold_cycles: expected %0d, actual %0d",
                               exp_ph.hold_cycles, o_hold_cycles);
                        errors = errors + 1;
                    end
                    if (o_last_phase !== exp_ph.last_phase) begin
                        $error("last_phase: expected %0b, actual %0b",
                               exp_ph.last_phase, o_last_phase);
                        errors = errors + 1;
                    end
                end
                // close the word: directed rows also carry a hand-typed count
                if (o_last_phase) begin
                    if (typed_counts.size() != 0) begin
                        typed = typed_counts.pop_front();
                        if (typed != UNTYPED && typed != phases_this_word) begin
                            $error("phase count: expected %0d, actual %0d",
                                   typed, phases_this_word);
                            errors = errors + 1;
                        end
                    end
                    phases_this_word = 0;
                end
            end
        end
    end

    // Receiver: after each phase word taken, stall for a fresh random spell drawn by draw_gap.
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            n = draw_gap();
            i_ready    <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end else if (!i_ready) begin
            if (stall_left == 0) i_ready <= 1'b1;
            else stall_left <= stall_left - 1;
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one frame word after a random gap and returns at the edge that takes it.
    // Valid is left high so that a zero gap next time runs back to back.
    task automatic send_word(input logic [7:0] data, input logic first, input logic last,
                             input int phases);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= data;
        i_first_byte <= first;
        i_last_byte  <= last;
        word_phases  <= phases;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Holds off the sender until every expected phase word is out, then writes
    // the delay register with the block idle.
    task automatic drain_and_set_delay(input logic [DELAY_W-1:0] value);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_phases.size() != 0);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        logic [DELAY_W-1:0] dly;

        // set_delay, delay, byte, first, last, phases
        directed_rows = '{
            '{1'b0, 16'd0,     8'h00, 1'b1, 1'b1, 33},  // reset delay, all-zero byte
            '{1'b0, 16'd0,     8'hFF, 1'b1, 1'b1, 33},  // all-ones byte
            '{1'b0, 16'd0,     8'h55, 1'b0, 1'b0, 27},  // bare byte after a stop
            '{1'b0, 16'd0,     8'hAA, 1'b1, 1'b0, 29},  // start only
            '{1'b0, 16'd0,     8'h3C, 1'b0, 1'b0, 27},  // no start after no stop
            '{1'b0, 16'd0,     8'h81, 1'b0, 1'b1, 31},  // stop only
            '{1'b1, 16'd0,     8'hFF, 1'b1, 1'b1, 33},  // zero delay passed through
            '{1'b0, 16'd0,     8'h01, 1'b0, 1'b0, 27},
            '{1'b1, 16'hFFFF,  8'h80, 1'b1, 1'b1, 33},  // largest delay
            '{1'b0, 16'd0,     8'h7E, 1'b0, 1'b0, 27},
            '{1'b1, 16'd1,     8'hA5, 1'b1, 1'b1, 33},  // smallest legal delay
            '{1'b0, 16'd0,     8'h5A, 1'b1, 1'b0, 29},
            '{1'b0, 16'd0,     8'hC3, 1'b0, 1'b1, 31},
            '{1'b1, 16'd100,   8'h0F, 1'b1, 1'b1, 33}   // back to the reset value
        };

        // synchronous reset, held at the start, never again
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, first rows on the reset delay
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].set_delay) drain_and_set_delay(directed_rows[r].delay);
            send_word(directed_rows[r].data, directed_rows[r].first,
                      directed_rows[r].last, directed_rows[r].phases);
        end

        // random part: blocks of words, each on a fresh delay written while idle
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case (blk)
                0:       dly = 16'd1;
                1:       dly = 16'hFFFF;
                default: dly = DELAY_W'($urandom_range(1, 65535));
            endcase
            drain_and_set_delay(dly);
            sent = 0;
            while (sent < WORDS_PER_BLOCK) begin
                quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0) begin
                    // stray word, flags at random
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), UNTYPED);
                    sent = sent + 1;
                end else begin
                    // well-formed frame: start on the first word, stop on the last
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++) begin
                        send_word(8'($urandom_range(0, 255)), i == 0, i == len - 1, UNTYPED);
                    end
                    sent = sent + len;
                end
            end
        end
        quiet = 1'b0;

        // drain, then give any stray phase words time to show up
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_phases.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && pending_phases.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
